// File: rtl/searchable_stack_core_defines.svh
// ----------------------------------------------------------------------------
// Searchable stack assertion macros
// Concurrent assertion wrappers used by the searchable stack core.
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_STACK_CORE_DEFINES_SVH
`define SEARCHABLE_STACK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked assertion, ignored while reset is high.
`define SSK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("searchable stack assertion failed");

// Clocked assertion that also holds during reset.
`define SSK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("searchable stack assertion failed");

`else

`define SSK_ASSERT(lbl, clk, rst, prop)
`define SSK_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/ssk_pkg.sv
// ----------------------------------------------------------------------------
// Searchable stack package
// Shared widths, codes and the per-cell command bundle.
// ----------------------------------------------------------------------------
package ssk_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int POS_W         = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH   = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_FIND   = 2'd2,
      MODE_LIST   = 2'd3
   } ssk_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } ssk_status_type;

   // Broadcast command to every cell of the chain.
   typedef struct packed {
      logic push;    // shift toward the bottom, top takes the new value
      logic del;     // cells at or below the hit take their lower neighbor
      logic rot;     // rotate one place toward the top (list walk)
   } ssk_cmd_type;

endpackage

// File: rtl/ssk_cell.sv
// ----------------------------------------------------------------------------
// Searchable stack cell
// One stack slot: holds a value, compares it, and takes a neighbor's value.
// ----------------------------------------------------------------------------
module ssk_cell (
   input  logic                                clock,
   input  ssk_pkg::ssk_cmd_type                cmd,
   input  logic                                del_sel,
   input  logic                                tail_sel,
   input  logic signed [ssk_pkg::DATA_W-1:0]   upper_data,
   input  logic signed [ssk_pkg::DATA_W-1:0]   lower_data,
   input  logic signed [ssk_pkg::DATA_W-1:0]   head_data,
   input  logic signed [ssk_pkg::DATA_W-1:0]   cmp_value,
   output logic signed [ssk_pkg::DATA_W-1:0]   data,
   output logic                                match
);
   import ssk_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      priority if (cmd.push) begin
         data_in = upper_data;
      end else if (cmd.del && del_sel) begin
         data_in = lower_data;
      end else if (cmd.rot) begin
         // the tail slot closes the ring by taking the head
         data_in = tail_sel ? head_data : lower_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == cmp_value);

endmodule

// File: rtl/searchable_stack_core.sv
// ----------------------------------------------------------------------------
// Searchable stack core
// LIFO of signed 32-bit values with find, delete-first-match and list.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_mode/req_value and raise start; the beat is
//   taken on a rising edge with start high and busy low.
//   Result channel: each result is on the rsp_ ports for exactly one cycle,
//   flagged by rsp_strobe; the receiver cannot stall it.
//   The registered first result shows in the cycle after the command is taken.
//   Throughput: push, delete and find may follow back to back. A list of N
//   entries emits N beats back to back and holds busy high while every
//   beat but the last is shown; an empty list gives one beat. The list walk
//   rotates the cell chain once around, one place per cycle, so the chain
//   is back in order when busy drops.
//   Storage: a chain of DEPTH cells, cell 0 is the top of the stack. Every
//   cell compares against req_value in parallel; the nearest hit to the top
//   is picked by a one-hot isolate.
//   Reset: fill count and list walk clear; stored values are not cleared.
// ----------------------------------------------------------------------------
`include "searchable_stack_core_defines.svh"

module searchable_stack_core #(
   parameter int DEPTH = ssk_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ssk_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [ssk_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic [ssk_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ssk_pkg::DATA_W-1:0]   rsp_entry_value,
   output logic [ssk_pkg::POS_W-1:0]           rsp_position,
   output logic                                rsp_last
);
   import ssk_pkg::*;

   localparam int CW    = $clog2(DEPTH + 1);           // fill count width
   localparam int IW    = $clog2(DEPTH);               // cell index width
   localparam int PAD_W = (IW > POS_W) ? IW : POS_W;

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] list_left_ff, list_left_in;
   logic [IW-1:0] list_pos_ff, list_pos_in;
   logic          rsp_strobe_ff, rsp_strobe_in;

   // result payload
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [IW-1:0]             rsp_pos_ff, rsp_pos_in;
   logic                      rsp_last_ff, rsp_last_in;

   // cell chain
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]         cell_match;
   logic [DEPTH-1:0]         cell_valid;
   logic [DEPTH-1:0]         tail_sel;
   logic [DEPTH-1:0]         hit_vec;
   logic [DEPTH-1:0]         first_hit;
   logic [DEPTH-1:0]         del_mask;
   ssk_cmd_type              cmd;

   logic          accept;
   logic          empty;
   logic          full;
   logic          found;
   logic          walking;
   logic [CW-1:0] count_m1;
   logic [IW-1:0] hit_pos;
   logic [PAD_W-1:0] pos_pad;
   ssk_mode_type  mode;

   assign accept   = start && !busy;
   assign mode     = ssk_mode_type'(req_mode);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign walking  = (list_left_ff != '0);
   assign busy     = walking;
   assign count_m1 = count_ff - CW'(1);

   // occupancy and tail flags per cell
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         cell_valid[k] = (CW'(k) < count_ff);
         tail_sel[k]   = (CW'(k) == count_m1);
      end
   end

   // nearest hit to the top is the lowest set bit; the delete mask covers
   // that cell and every cell below it
   assign hit_vec   = cell_match & cell_valid;
   assign found     = |hit_vec;
   assign first_hit = hit_vec & (~hit_vec + DEPTH'(1));
   assign del_mask  = ~(first_hit - DEPTH'(1));

   always_comb begin
      hit_pos = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (first_hit[k]) begin
            hit_pos = hit_pos | IW'(k);
         end
      end
   end

   always_comb begin
      cmd.push = accept && (mode == MODE_PUSH) && !full;
      cmd.del  = accept && (mode == MODE_DELETE) && found;
      cmd.rot  = (accept && (mode == MODE_LIST) && !empty) || walking;
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [DATA_W-1:0] upper;
         logic signed [DATA_W-1:0] lower;

         if (g == 0) begin : g_top
            assign upper = req_value;
         end else begin : g_mid_up
            assign upper = cell_data[g-1];
         end

         if (g == DEPTH - 1) begin : g_bottom
            assign lower = '0;
         end else begin : g_mid_dn
            assign lower = cell_data[g+1];
         end

         ssk_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .del_sel    (del_mask[g]),
            .tail_sel   (tail_sel[g]),
            .upper_data (upper),
            .lower_data (lower),
            .head_data  (cell_data[0]),
            .cmp_value  (req_value),
            .data       (cell_data[g]),
            .match      (cell_match[g])
         );
      end
   endgenerate

   // next state and result beat
   always_comb begin
      count_in      = count_ff;
      list_left_in  = list_left_ff;
      list_pos_in   = list_pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_pos_in    = '0;
      rsp_last_in   = 1'b1;

      if (walking) begin
         rsp_strobe_in = 1'b1;
         rsp_value_in  = cell_data[0];
         rsp_pos_in    = list_pos_ff;
         rsp_last_in   = (list_left_ff == CW'(1));
         list_left_in  = list_left_ff - CW'(1);
         list_pos_in   = list_pos_ff + IW'(1);
      end else if (accept) begin
         rsp_strobe_in = 1'b1;
         unique case (mode)
            MODE_PUSH: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            MODE_DELETE: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (!found) begin
                  rsp_status_in = ST_NOTFOUND;
               end else begin
                  count_in = count_m1;
               end
            end
            MODE_FIND: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (!found) begin
                  rsp_status_in = ST_NOTFOUND;
               end else begin
                  rsp_value_in = req_value;
                  rsp_pos_in   = hit_pos;
               end
            end
            MODE_LIST: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_value_in = cell_data[0];
                  rsp_last_in  = (count_ff == CW'(1));
                  list_left_in = count_m1;
                  list_pos_in  = IW'(1);
               end
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         list_left_ff  <= '0;
         list_pos_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         list_left_ff  <= list_left_in;
         list_pos_ff   <= list_pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // position keeps its low bits only on deep configurations
   assign pos_pad = PAD_W'(rsp_pos_ff);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_position    = pos_pad[POS_W-1:0];
   assign rsp_last        = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `SSK_ASSERT_ALWAYS(a_count_bound, clock, (!reset |-> (count_ff <= CW'(DEPTH))))
   `SSK_ASSERT(a_accept_gives_beat, clock, reset, (accept |=> rsp_strobe_ff))
   `SSK_ASSERT(a_walk_gives_beat, clock, reset, (walking |=> rsp_strobe_ff))
   `SSK_ASSERT(a_open_list_busy, clock, reset, ((rsp_strobe_ff && !rsp_last_ff) |-> walking))
   `SSK_ASSERT(a_single_hit, clock, reset, $onehot0(first_hit))
   `SSK_ASSERT(a_walk_holds_count, clock, reset, (walking |=> $stable(count_ff)))

endmodule
